// ===== src/wpm_pkg.sv =====
// ----------------------------------------------------------------------------
// wpm_pkg
// Shared constants, codes and types of the wildcard pattern matcher.
// ----------------------------------------------------------------------------
package wpm_pkg;

    localparam int MAX_PATTERN = 128;
    localparam int CHAR_W      = 8;
    localparam int ACT_W       = 2;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    localparam logic [CHAR_W-1:0] CH_ONE = 8'h3F;
    localparam logic [CHAR_W-1:0] CH_ANY = 8'h2A;

    typedef enum logic [ACT_W-1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_NAME   = 2'd2,
        ACT_END    = 2'd3
    } t_act;

    typedef struct packed {
        t_act              act;
        logic [CHAR_W-1:0] ch;
    } t_op;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_op_q;

endpackage

// ===== src/wpm_if.sv =====
// ----------------------------------------------------------------------------
// wpm_if
// Valid/ready channels of the matcher: input words and result words.
// ----------------------------------------------------------------------------
interface wpm_item_if;
    logic                       valid;
    logic                       ready;
    logic [wpm_pkg::ACT_W-1:0]  action;
    logic [wpm_pkg::CHAR_W-1:0] char_code;

    modport source (output valid, output action, output char_code, input ready);
    modport sink   (input valid, input action, input char_code, output ready);
endinterface

interface wpm_result_if;
    logic valid;
    logic ready;
    logic matched;
    logic pattern_overflow;

    modport source (output valid, output matched, output pattern_overflow, input ready);
    modport sink   (input valid, input matched, input pattern_overflow, output ready);
endinterface

// ===== src/wpm_front.sv =====
// ----------------------------------------------------------------------------
// wpm_front
// Accepts input words, decodes the action and queues them for the engine.
// ----------------------------------------------------------------------------
module wpm_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    wpm_item_if.sink         i_req,
    output wpm_pkg::t_op_q   o_head,
    input  logic             i_pop
);

    wpm_pkg::t_op r_queue [2];
    logic         r_wr;
    logic         r_rd;
    logic [1:0]   r_count;
    logic [1:0]   n_count;
    logic         push;

    assign i_req.ready  = (r_count != 2'd2);
    assign push         = i_req.valid && i_req.ready;
    assign o_head.valid = (r_count != 2'd0);
    assign o_head.op    = r_queue[r_rd];

    always_comb begin
        n_count = r_count;
        if (push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr].act <= wpm_pkg::t_act'(i_req.action);
            r_queue[r_wr].ch  <= i_req.char_code;
        end
    end

endmodule

// ===== src/wpm_back.sv =====
// ----------------------------------------------------------------------------
// wpm_back
// Pattern store, position tracking; one word per cycle unless results stall.
// ----------------------------------------------------------------------------
module wpm_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  wpm_pkg::t_op_q   i_head,
    output logic             o_pop,
    wpm_result_if.source     o_rsp
);

    logic [wpm_pkg::CHAR_W-1:0]    r_store [wpm_pkg::MAX_PATTERN];
    logic [wpm_pkg::LEN_W-1:0]     r_len;
    logic                          r_ovf;
    logic [wpm_pkg::MAX_PATTERN:0] r_seed;
    logic                          r_out_valid;
    logic                          r_out_match;
    logic                          r_out_ovf;

    logic [wpm_pkg::MAX_PATTERN-1:0] len_mask;
    logic [wpm_pkg::MAX_PATTERN-1:0] star_m;
    logic [wpm_pkg::MAX_PATTERN-1:0] hit_m;
    logic [wpm_pkg::MAX_PATTERN-1:0] seed_star;
    logic [wpm_pkg::MAX_PATTERN:0]   sum;
    logic [wpm_pkg::MAX_PATTERN:0]   carry;
    logic [wpm_pkg::MAX_PATTERN:0]   act;
    logic [wpm_pkg::MAX_PATTERN-1:0] stay;
    logic [wpm_pkg::MAX_PATTERN-1:0] step;
    logic [wpm_pkg::MAX_PATTERN:0]   n_seed;
    logic                            can_take;
    logic                            has_room;

    for (genvar i = 0; i < wpm_pkg::MAX_PATTERN; i++) begin : g_pos
        assign len_mask[i] = (wpm_pkg::LEN_W'(i) < r_len);
        assign star_m[i]   = len_mask[i] && (r_store[i] == wpm_pkg::CH_ANY);
        assign hit_m[i]    = len_mask[i] && !star_m[i]
                             && ((r_store[i] == wpm_pkg::CH_ONE)
                                 || (r_store[i] == i_head.op.ch));
    end

    // close over runs of stars: carries of star_m + (seed & star_m)
    assign seed_star = r_seed[wpm_pkg::MAX_PATTERN-1:0] & star_m;
    assign sum       = {1'b0, star_m} + {1'b0, seed_star};
    assign carry     = sum ^ {1'b0, star_m} ^ {1'b0, seed_star};
    assign act       = r_seed | carry;

    assign stay   = act[wpm_pkg::MAX_PATTERN-1:0] & star_m;
    assign step   = act[wpm_pkg::MAX_PATTERN-1:0] & hit_m;
    assign n_seed = {1'b0, stay} | {step, 1'b0};

    assign has_room = (r_len < wpm_pkg::LEN_W'(wpm_pkg::MAX_PATTERN));
    assign can_take = !r_out_valid || o_rsp.ready;
    assign o_pop    = i_head.valid && ((i_head.op.act != wpm_pkg::ACT_END) || can_take);

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.matched          = r_out_match;
    assign o_rsp.pattern_overflow = r_out_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_seed      <= (wpm_pkg::MAX_PATTERN + 1)'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop && (i_head.op.act == wpm_pkg::ACT_END)) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                case (i_head.op.act)
                    wpm_pkg::ACT_CLEAR: begin
                        r_len  <= '0;
                        r_ovf  <= 1'b0;
                        r_seed <= (wpm_pkg::MAX_PATTERN + 1)'(1);
                    end
                    wpm_pkg::ACT_APPEND: begin
                        if (has_room) begin
                            r_len <= r_len + wpm_pkg::LEN_W'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        r_seed <= (wpm_pkg::MAX_PATTERN + 1)'(1);
                    end
                    wpm_pkg::ACT_NAME: begin
                        r_seed <= n_seed;
                    end
                    wpm_pkg::ACT_END: begin
                        r_seed <= (wpm_pkg::MAX_PATTERN + 1)'(1);
                    end
                    default: begin
                        r_seed <= (wpm_pkg::MAX_PATTERN + 1)'(1);
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && (i_head.op.act == wpm_pkg::ACT_APPEND) && has_room) begin
            r_store[r_len[wpm_pkg::IDX_W-1:0]] <= i_head.op.ch;
        end
        if (o_pop && (i_head.op.act == wpm_pkg::ACT_END)) begin
            r_out_match <= act[r_len];
            r_out_ovf   <= r_ovf;
        end
    end

endmodule

// ===== src/wildcard_pattern_matcher.sv =====
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher
// Matches streamed names against a stored '?' / '*' wildcard pattern.
//
//   channel   dir  handshake     payload
//   i_req     in   valid/ready   action[1:0], char_code[7:0]
//   o_rsp     out  valid/ready   matched, pattern_overflow
//
// One word per cycle sustained while results are taken.
// An end-of-name word is queued, then its result is registered at the output.
// The star closure is one carry chain across the position vector.
// Reset (synchronous) clears length, overflow and tracking; the store is not reset.
// A stalled result holds the engine only at the next end-of-name word.
// ----------------------------------------------------------------------------
module wildcard_pattern_matcher (
    input  logic          i_clk,
    input  logic          i_rst_n,
    wpm_item_if.sink      i_req,
    wpm_result_if.source  o_rsp
);

    wpm_pkg::t_op_q head;
    logic           pop;

    wpm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_head  (head),
        .i_pop   (pop)
    );

    wpm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_rsp   (o_rsp)
    );

endmodule
